// File: hw/rtl/mfr_pkg.sv
// Shared types and constants of the one-bit framebuffer to RGB565 expander.
package mfr_pkg;

  localparam int LANES            = 8;
  localparam int INDEX_W          = 18;
  localparam int COLOR_W          = 16;
  localparam int DIM_W            = 10;
  localparam int KIND_W           = 2;
  localparam int CFG_INDEX_W      = 3;
  localparam int CFG_DATA_W       = 16;
  localparam int COUNT_W          = 4;
  localparam int TOP_BAND_LAST    = 13;
  localparam int BOTTOM_BAND_ROWS = 18;

  localparam logic [KIND_W-1:0]  KIND_THEME  = 2'd0;
  localparam logic [KIND_W-1:0]  KIND_EPAPER = 2'd2;

  localparam logic [DIM_W-1:0]   WIDTH_RESET  = 10'd480;
  localparam logic [DIM_W-1:0]   HEIGHT_RESET = 10'd272;
  localparam logic [COLOR_W-1:0] WHITE        = 16'hFFFF;
  localparam logic [COLOR_W-1:0] BLACK        = 16'h0000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DISPLAY_KIND = 3'd0,
    REG_FRAME_WIDTH  = 3'd1,
    REG_FRAME_HEIGHT = 3'd2,
    REG_THEME_FG     = 3'd3,
    REG_THEME_BG     = 3'd4,
    REG_PANEL_FG     = 3'd5,
    REG_PANEL_BG     = 3'd6,
    REG_ACCENT_COLOR = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [KIND_W-1:0]  display_kind;
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [COLOR_W-1:0] theme_fg;
    logic [COLOR_W-1:0] theme_bg;
    logic [COLOR_W-1:0] panel_fg;
    logic [COLOR_W-1:0] panel_bg;
    logic [COLOR_W-1:0] accent_color;
  } cfg_t;

  // Everything the lanes need to expand one byte.
  typedef struct packed {
    logic [7:0]         fb_byte;
    logic [INDEX_W-1:0] row_base;
    logic [INDEX_W-1:0] x0;
    logic [COUNT_W-1:0] count;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic [COLOR_W-1:0] accent;
    logic               accent_en;
    logic               frame_end;
  } byte_info_t;

  typedef struct packed {
    logic [INDEX_W-1:0] pixel_index;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_of_byte;
    logic               frame_done;
  } pixel_t;

  typedef pixel_t [LANES-1:0] pixel_set_t;

endpackage

// File: hw/rtl/mfr_in_if.sv
// Input channel carrying one framebuffer byte per beat.
interface mfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] fb_byte;

  modport source (output valid, output fb_byte, input ready);
  modport sink   (input valid, input fb_byte, output ready);
endinterface

// File: hw/rtl/mfr_out_if.sv
// Result channel carrying one RGB565 pixel per beat.
interface mfr_out_if;
  logic        valid;
  logic        ready;
  logic [17:0] pixel_index;
  logic [15:0] pixel_color;
  logic        last_of_byte;
  logic        frame_done;

  modport source (output valid, output pixel_index, output pixel_color,
                  output last_of_byte, output frame_done, input ready);
  modport sink   (input valid, input pixel_index, input pixel_color,
                  input last_of_byte, input frame_done, output ready);
endinterface

// File: hw/rtl/mfr_walker.sv
// Row and byte position tracker that prepares the per-byte expansion data.
module mfr_walker #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mfr_pkg::cfg_t       cfg,
  input  logic                in_valid,
  input  logic [7:0]          in_byte,
  output logic                in_ready,
  output logic                info_valid,
  output mfr_pkg::byte_info_t info,
  input  logic                info_take
);
  import mfr_pkg::*;

  localparam int W_CAP = (MAX_WIDTH < 1023) ? MAX_WIDTH : 1023;
  localparam int H_CAP = (MAX_HEIGHT < 1023) ? MAX_HEIGHT : 1023;
  localparam int WB    = $clog2(W_CAP + 1);
  localparam int HB    = $clog2(H_CAP + 1);
  localparam int RB    = $clog2(H_CAP);
  localparam int CBN   = (W_CAP + 7) / 8;
  localparam int CB    = (CBN > 1) ? $clog2(CBN) : 1;
  localparam int PW    = RB + WB;

  logic [CB-1:0]      col_r, col_nxt;
  logic [RB-1:0]      row_r, row_nxt;
  logic               info_valid_r, info_valid_nxt;
  byte_info_t         info_r, info_nxt;

  logic [WB-1:0]      w;
  logic [HB-1:0]      h;
  logic [WB:0]        w_p7;
  logic [WB-3:0]      bytes_per_row;
  logic [RB-1:0]      r0;
  logic [CB-1:0]      c0;
  logic [RB:0]        r0_p1;
  logic [RB:0]        rw_p1;
  logic [CB:0]        c0_p1;
  logic [CB+2:0]      x0;
  logic [WB:0]        diff;
  logic [PW-1:0]      prod;
  logic               band;
  logic               accept;

  assign in_ready   = !info_valid_r || info_take;
  assign accept     = in_valid && in_ready;
  assign info_valid = info_valid_r;
  assign info       = info_r;

  always_comb begin
    if (cfg.frame_width == '0) begin
      w = WB'(1);
    end else if (32'(cfg.frame_width) > W_CAP) begin
      w = WB'(W_CAP);
    end else begin
      w = WB'(cfg.frame_width);
    end
    if (cfg.frame_height == '0) begin
      h = HB'(1);
    end else if (32'(cfg.frame_height) > H_CAP) begin
      h = HB'(H_CAP);
    end else begin
      h = HB'(cfg.frame_height);
    end
    w_p7          = {1'b0, w} + (WB+1)'(7);
    bytes_per_row = w_p7[WB:3];

    // Recover from a geometry change that left the counters out of range.
    r0 = row_r;
    c0 = col_r;
    if (32'(row_r) >= 32'(h)) begin
      r0 = '0;
      c0 = '0;
    end
    rw_p1 = {1'b0, r0} + (RB+1)'(1);
    if (32'(c0) >= 32'(bytes_per_row)) begin
      c0 = '0;
      r0 = (32'(rw_p1) >= 32'(h)) ? '0 : rw_p1[RB-1:0];
    end

    r0_p1 = {1'b0, r0} + (RB+1)'(1);
    c0_p1 = {1'b0, c0} + (CB+1)'(1);
    x0    = {c0, 3'b000};
    diff  = {1'b0, w} - (WB+1)'(x0);
    prod  = PW'(r0) * PW'(w);
    band  = (32'(r0) <= TOP_BAND_LAST) || (32'(h) < BOTTOM_BAND_ROWS) ||
            (32'(r0) + BOTTOM_BAND_ROWS >= 32'(h));

    info_nxt.fb_byte   = in_byte;
    info_nxt.row_base  = INDEX_W'(prod);
    info_nxt.x0        = INDEX_W'(x0);
    info_nxt.count     = (32'(diff) > LANES) ? COUNT_W'(LANES) : diff[COUNT_W-1:0];
    info_nxt.fg        = (cfg.display_kind == KIND_THEME) ? cfg.theme_fg : cfg.panel_fg;
    info_nxt.bg        = (cfg.display_kind == KIND_THEME) ? cfg.theme_bg : cfg.panel_bg;
    info_nxt.accent    = cfg.accent_color;
    info_nxt.accent_en = (cfg.display_kind == KIND_EPAPER) && band;
    info_nxt.frame_end = (32'(r0_p1) == 32'(h)) &&
                         (32'(c0_p1) == 32'(bytes_per_row));

    if (32'(c0_p1) >= 32'(bytes_per_row)) begin
      col_nxt = '0;
      row_nxt = (32'(r0_p1) >= 32'(h)) ? '0 : r0_p1[RB-1:0];
    end else begin
      col_nxt = c0_p1[CB-1:0];
      row_nxt = r0;
    end

    if (accept) begin
      info_valid_nxt = 1'b1;
    end else if (info_take) begin
      info_valid_nxt = 1'b0;
    end else begin
      info_valid_nxt = info_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r        <= '0;
      row_r        <= '0;
      info_valid_r <= 1'b0;
    end else begin
      info_valid_r <= info_valid_nxt;
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      info_r <= info_nxt;
    end
  end

endmodule

// File: hw/rtl/mfr_lane.sv
// One expansion lane: turns one bit of the byte into a finished pixel.
module mfr_lane (
  input  mfr_pkg::byte_info_t info,
  input  logic [2:0]          lane_idx,
  output mfr_pkg::pixel_t     px
);
  import mfr_pkg::*;

  logic bit_set;
  logic is_last;

  always_comb begin
    bit_set = info.fb_byte[3'd7 - lane_idx];
    is_last = ({1'b0, lane_idx} + COUNT_W'(1)) == info.count;
    if (bit_set) begin
      px.pixel_color = info.bg;
    end else if (info.accent_en) begin
      px.pixel_color = info.accent;
    end else begin
      px.pixel_color = info.fg;
    end
    px.pixel_index  = info.row_base + info.x0 + INDEX_W'(lane_idx);
    px.last_of_byte = is_last;
    px.frame_done   = is_last && info.frame_end;
  end

endmodule

// File: hw/rtl/mfr_serializer.sv
// Merging stage: holds the lane results of one byte and sends them in order.
module mfr_serializer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  set_valid,
  input  mfr_pkg::pixel_set_t   set_in,
  input  logic [3:0]            set_count,
  output logic                  set_take,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mfr_pkg::pixel_t       out_px
);
  import mfr_pkg::*;

  pixel_set_t         set_r;
  logic [COUNT_W-1:0] cnt_r;
  logic [2:0]         ptr_r, ptr_nxt;
  logic               valid_r, valid_nxt;
  logic               at_last;
  logic               out_fire;

  assign at_last   = ({1'b0, ptr_r} + COUNT_W'(1)) == cnt_r;
  assign out_fire  = valid_r && out_ready;
  assign set_take  = set_valid && (!valid_r || (out_fire && at_last));
  assign out_valid = valid_r;
  assign out_px    = set_r[ptr_r];

  always_comb begin
    ptr_nxt   = ptr_r;
    valid_nxt = valid_r;
    if (set_take) begin
      ptr_nxt   = '0;
      valid_nxt = 1'b1;
    end else if (out_fire) begin
      if (at_last) begin
        valid_nxt = 1'b0;
      end else begin
        ptr_nxt = ptr_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      ptr_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (set_take) begin
      set_r <= set_in;
      cnt_r <= set_count;
    end
  end

endmodule

// File: hw/rtl/mono_framebuffer_to_rgb565.sv
// Top level of the one-bit framebuffer to RGB565 pixel expander.
//
//   channel   dir  handshake      payload
//   in_beat   in   valid/ready    fb_byte[7:0]
//   out_beat  out  valid/ready    pixel_index[17:0], pixel_color[15:0],
//                                 last_of_byte, frame_done
//   cfg_*     in   cfg_we only    cfg_index[2:0], cfg_wdata[15:0]
//
// Each input byte produces one output beat per active pixel it covers, so a
// full byte gives eight pixels and a padded byte at the end of a row fewer;
// the one-pixel-wide output port carries them one per beat. An input beat
// passes the walker and serializer registers before its first pixel leaves.
// The next byte is accepted while the current one is still being sent, so
// bytes follow each other without gaps. Reset (rst_n low, synchronous)
// clears the row and byte counters, empties the pipeline and loads the
// default register values. A stall on the output holds the current pixel
// and fills the byte stage, after which in_beat.ready drops.
module mono_framebuffer_to_rgb565 #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input  logic                            clk,
  input  logic                            rst_n,
  mfr_in_if.sink                          in_beat,
  mfr_out_if.source                       out_beat,
  input  logic                            cfg_we,
  input  logic [mfr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [mfr_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mfr_pkg::*;

  cfg_t        cfg_r;
  logic        info_valid;
  byte_info_t  info;
  logic        info_take;
  pixel_set_t  lane_px;
  pixel_t      out_px;
  logic        in_ready;
  logic        out_valid;

  // Config registers. User writes only while the block is idle; unchecked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.display_kind <= KIND_THEME;
      cfg_r.frame_width  <= WIDTH_RESET;
      cfg_r.frame_height <= HEIGHT_RESET;
      cfg_r.theme_fg     <= WHITE;
      cfg_r.theme_bg     <= BLACK;
      cfg_r.panel_fg     <= WHITE;
      cfg_r.panel_bg     <= BLACK;
      cfg_r.accent_color <= BLACK;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_DISPLAY_KIND: cfg_r.display_kind <= cfg_wdata[KIND_W-1:0];
        REG_FRAME_WIDTH:  cfg_r.frame_width  <= cfg_wdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: cfg_r.frame_height <= cfg_wdata[DIM_W-1:0];
        REG_THEME_FG:     cfg_r.theme_fg     <= cfg_wdata;
        REG_THEME_BG:     cfg_r.theme_bg     <= cfg_wdata;
        REG_PANEL_FG:     cfg_r.panel_fg     <= cfg_wdata;
        REG_PANEL_BG:     cfg_r.panel_bg     <= cfg_wdata;
        REG_ACCENT_COLOR: cfg_r.accent_color <= cfg_wdata;
        default:          cfg_r              <= cfg_r;
      endcase
    end
  end

  // The walker tracks the position in the frame and registers the row base,
  // pixel count and colour choice for the byte.
  mfr_walker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_walker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_beat.valid),
    .in_byte    (in_beat.fb_byte),
    .in_ready   (in_ready),
    .info_valid (info_valid),
    .info       (info),
    .info_take  (info_take)
  );

  assign in_beat.ready = in_ready;

  // Eight lanes expand all bits of the byte side by side.
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    mfr_lane u_lane (
      .info     (info),
      .lane_idx (3'(g)),
      .px       (lane_px[g])
    );
  end

  // The serializer captures the lane results and sends them one per beat.
  mfr_serializer u_serializer (
    .clk       (clk),
    .rst_n     (rst_n),
    .set_valid (info_valid),
    .set_in    (lane_px),
    .set_count (info.count),
    .set_take  (info_take),
    .out_valid (out_valid),
    .out_ready (out_beat.ready),
    .out_px    (out_px)
  );

  assign out_beat.valid        = out_valid;
  assign out_beat.pixel_index  = out_px.pixel_index;
  assign out_beat.pixel_color  = out_px.pixel_color;
  assign out_beat.last_of_byte = out_px.last_of_byte;
  assign out_beat.frame_done   = out_px.frame_done;

endmodule
